[src/arpc_pkg.sv]
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the ARP cache: field widths, the request
// broadcast to every cell, the token that walks the cell chain and the
// end-of-pass commit.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int CACHE_DEPTH_DEF = 128;

  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int TIME_W = 32;
  localparam int AGE_W  = 16;

  localparam logic [AGE_W-1:0] AGE_RESET = AGE_W'(10);

  // request kinds
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  // request held at the top and seen by every cell
  typedef struct packed {
    logic              req_type;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] now;
    logic [AGE_W-1:0]  max_age;
  } req_t;

  // token handed from cell to cell, one cell per cycle
  typedef struct packed {
    logic             active;
    logic             found;
    logic [MAC_W-1:0] mac_out;
    logic             matched;
    logic             claimed;
  } tok_t;

  // end of pass, broadcast to every cell
  typedef struct packed {
    logic done;
    logic write;
  } commit_t;

  // one result item
  typedef struct packed {
    logic             found;
    logic [MAC_W-1:0] mac_out;
    logic             insert_ok;
  } result_t;

endpackage

[src/arpc_req_if.sv]
// ----------------------------------------------------------------------------
// arpc_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface arpc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] ip_addr;
  logic [47:0] mac_in;
  logic [31:0] now_seconds;

  modport source (output valid, req_type, ip_addr, mac_in, now_seconds, input ready);
  modport sink   (input valid, req_type, ip_addr, mac_in, now_seconds, output ready);
endinterface

[src/arpc_res_if.sv]
// ----------------------------------------------------------------------------
// arpc_res_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface arpc_res_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [47:0] mac_out;
  logic        insert_ok;

  modport source (output valid, found, mac_out, insert_ok, input ready);
  modport sink   (input valid, found, mac_out, insert_ok, output ready);
endinterface

[src/arpc_cell.sv]
// ----------------------------------------------------------------------------
// arpc_cell
// One cache entry. Ages, matches and updates itself when the token passes,
// then hands the token on to the next cell. An insert that finds no
// matching address tentatively claims the first free entry; the claim is
// made good or dropped by the commit at the end of the pass.
// ----------------------------------------------------------------------------
module arpc_cell (
  input  logic              clk,
  input  logic              rst,
  input  arpc_pkg::req_t    req,
  input  arpc_pkg::commit_t commit,
  input  arpc_pkg::tok_t    tok_in,
  output arpc_pkg::tok_t    tok_out
);
  import arpc_pkg::*;

  logic [IP_W-1:0]   ip;
  logic [MAC_W-1:0]  mac;
  logic [TIME_W-1:0] stamp;
  logic              valid;
  logic              pending;

  logic [TIME_W-1:0] age;
  logic              expired;
  logic              valid_aged;
  logic              ip_eq;
  logic              hit;
  logic              take;
  logic              claim;
  logic              is_insert;
  tok_t              tok_next;

  // aging and matching against the broadcast request
  always_comb begin
    age        = req.now - stamp;
    expired    = age > {{(TIME_W-AGE_W){1'b0}}, req.max_age};
    valid_aged = valid && !expired;
    ip_eq      = ip == req.ip;
    is_insert  = req.req_type == REQ_INSERT;
    hit        = !is_insert && valid_aged && ip_eq;
    take       = is_insert && ip_eq && !tok_in.matched;
    claim      = is_insert && !valid_aged && !tok_in.claimed;
  end

  // token update for the next cell
  always_comb begin
    tok_next         = tok_in;
    tok_next.found   = tok_in.found || hit;
    tok_next.mac_out = (!tok_in.found && hit) ? mac : tok_in.mac_out;
    tok_next.matched = tok_in.matched || take;
    tok_next.claimed = tok_in.claimed || claim;
  end

  // entry control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ip      <= '0;
      valid   <= 1'b0;
      pending <= 1'b0;
    end else if (commit.done) begin
      pending <= 1'b0;
      if (commit.write && pending) begin
        ip    <= req.ip;
        valid <= 1'b1;
      end
    end else if (tok_in.active) begin
      if (take) begin
        valid <= 1'b1;
      end else begin
        valid <= valid_aged;
        if (claim) begin
          pending <= 1'b1;
        end
      end
    end
  end

  // entry payload, written on a match or a tentative claim
  always_ff @(posedge clk) begin
    if (tok_in.active && (take || claim)) begin
      mac   <= req.mac;
      stamp <= req.now;
    end
  end

  // hand the token on
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_in.active ? tok_next : '0;
    end
  end

  // a claimed entry stays invalid until the commit
  a_pending_invalid: assert property (@(posedge clk) disable iff (rst)
    pending |-> !valid)
    else $error("claimed entry is valid");

  // at most one entry is matched in one pass
  a_single_take: assert property (@(posedge clk) disable iff (rst)
    (tok_in.active && tok_in.matched) |-> !take)
    else $error("second match taken in one pass");

  // a pending claim is cleared at the end of every pass
  a_claim_cleared: assert property (@(posedge clk) disable iff (rst)
    commit.done |=> !pending)
    else $error("claim survived end of pass");

endmodule

[src/arp_cache_with_aging.sv]
// ----------------------------------------------------------------------------
// arp_cache_with_aging
// IPv4-to-MAC cache with aging, built as a chain of entry cells.
// ----------------------------------------------------------------------------
// A transferred request starts one token that walks the row of entry cells,
// one cell per cycle, aging each entry, matching the address and collecting
// the lookup result. At the end of the pass the commit writes an insert
// that matched no address into the first free entry and the result is
// staged. The result waits in an output register (plus one holding stage)
// so a new request can be taken while the previous result is not yet
// transferred. The max_age register is written through cfg_we/cfg_wdata;
// the user must write it only while idle; the block does not enforce this.
module arp_cache_with_aging #(
  parameter int CACHE_DEPTH = arpc_pkg::CACHE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  arpc_req_if.sink                    req,
  arpc_res_if.source                  res,
  input  logic                        cfg_we,
  input  logic [arpc_pkg::AGE_W-1:0]  cfg_wdata
);
  import arpc_pkg::*;

  logic [AGE_W-1:0] max_age;
  req_t             req_q;
  req_t             req_bcast;
  logic             busy;
  logic             start_active;
  logic             accept;
  logic             done;
  logic             out_free;
  logic             out_valid;
  result_t          out_res;
  logic             hold_valid;
  result_t          hold_res;
  result_t          res_new;
  commit_t          commit;
  tok_t             tok [CACHE_DEPTH+1];

  // handshake
  assign req.ready = !busy && !hold_valid;
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || res.ready;

  // request broadcast to the cells
  always_comb begin
    req_bcast         = req_q;
    req_bcast.max_age = max_age;
  end

  // token entering the first cell
  always_comb begin
    tok[0]        = '0;
    tok[0].active = start_active;
  end

  // end of pass
  assign done = tok[CACHE_DEPTH].active;
  always_comb begin
    commit.done  = done;
    commit.write = (req_q.req_type == REQ_INSERT) && !tok[CACHE_DEPTH].matched;
  end

  // result of the finished pass
  always_comb begin
    res_new.found     = tok[CACHE_DEPTH].found;
    res_new.mac_out   = tok[CACHE_DEPTH].mac_out;
    res_new.insert_ok = (req_q.req_type == REQ_INSERT) &&
                        (tok[CACHE_DEPTH].matched || tok[CACHE_DEPTH].claimed);
  end

  // row of entry cells
  for (genvar i = 0; i < CACHE_DEPTH; i++) begin : g_cell
    arpc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .req     (req_bcast),
      .commit  (commit),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q.req_type <= req.req_type;
      req_q.ip       <= req.ip_addr;
      req_q.mac      <= req.mac_in;
      req_q.now      <= req.now_seconds;
      req_q.max_age  <= '0;
    end
  end

  // control, configuration and result staging
  always_ff @(posedge clk) begin
    if (rst) begin
      max_age      <= AGE_RESET;
      busy         <= 1'b0;
      start_active <= 1'b0;
      out_valid    <= 1'b0;
      out_res      <= '0;
      hold_valid   <= 1'b0;
      hold_res     <= '0;
    end else begin
      if (cfg_we) begin
        max_age <= cfg_wdata;
      end
      start_active <= accept;
      if (accept) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (done) begin
        if (out_free) begin
          out_res   <= res_new;
          out_valid <= 1'b1;
        end else begin
          hold_res   <= res_new;
          hold_valid <= 1'b1;
        end
      end else if (out_free) begin
        out_res    <= hold_res;
        out_valid  <= hold_valid;
        hold_valid <= 1'b0;
      end
    end
  end

  // result port
  assign res.valid     = out_valid;
  assign res.found     = out_res.found;
  assign res.mac_out   = out_res.mac_out;
  assign res.insert_ok = out_res.insert_ok;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("request transfer did not start a pass");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("pass finished while idle");

  a_hold_behind_out: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> out_valid)
    else $error("holding stage full with output register empty");

  a_no_token_while_held: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> !busy)
    else $error("pass running while a result is held");

endmodule
